/* hdl/irmm_pkg.sv */
// shared types and constants for the invariant range and mask monitor
`default_nettype none

package irmm_pkg;

    // configuration port
    localparam int unsigned APB_ADDR_W = 4;
    localparam int unsigned APB_DATA_W = 32;

    typedef enum logic [1:0] {
        REG_TRAINING_MODE = 2'd0,
        REG_ERROR_LIMIT   = 2'd1,
        REG_RUN_NUMBER    = 2'd2
    } t_reg_index;

    // item commands
    localparam logic OP_OBSERVE   = 1'b0;
    localparam logic OP_INCREMENT = 1'b1;

    localparam logic [31:0] SIGN_BIAS = 32'h8000_0000;
    localparam logic [31:0] MASK_ONES = ~32'h0;
    localparam logic [7:0]  COUNT_MAX = 8'hFF;

    typedef enum logic [1:0] {
        KIND_UNSET    = 2'd0,
        KIND_SIGNED   = 2'd1,
        KIND_UNSIGNED = 2'd2
    } t_kind;

    // entry bookkeeping, cleared after reset
    typedef struct packed {
        t_kind       kind;
        logic [7:0]  count;
        logic [15:0] run;
    } t_ctrl_word;

    // trained values, written on first use
    typedef struct packed {
        logic [31:0] last;
        logic [31:0] low;
        logic [31:0] high;
        logic [31:0] first;
        logic [31:0] mask;
    } t_data_word;

    localparam int unsigned CTRL_W = $bits(t_ctrl_word);
    localparam int unsigned DATA_W = $bits(t_data_word);

    // order-preserving unsigned key
    function automatic logic [31:0] order_key(input logic [31:0] v, input logic sgn);
        order_key = sgn ? (v ^ SIGN_BIAS) : v;
    endfunction

endpackage

`default_nettype wire

/* hdl/invariant_range_mask_monitor.sv */
// invariant table monitor: training and checking of value ranges and stable bit masks
//
//   channel   direction  handshake                    payload
//   item in   input      i_in_valid / o_in_ready      cmd, type_index, entry_index, sample, is_signed
//   result    output     o_out_valid / i_out_ready    violations, abort, not_counter, error_count
//   config    input      apb psel/penable/pwrite      training_mode, error_limit, run_number
//
// each item is handled as a table read on acceptance, then modify and write back.
// the result lands in an output register, so the next item is taken while it waits.
// a result held by the sink stalls the write-back cycle until the register frees.
// after reset a clearing pass zeroes the bookkeeping memory, one entry a cycle,
// all TYPE_COUNT*ENTRIES_PER_TYPE entries (1024 by default), before the first item is taken.
`default_nettype none

module invariant_range_mask_monitor #(
    parameter int TYPE_COUNT       = 16,
    parameter int ENTRIES_PER_TYPE = 64
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // item input
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic                              i_cmd,
    input  wire logic [3:0]                        i_type_index,
    input  wire logic [5:0]                        i_entry_index,
    input  wire logic [31:0]                       i_sample,
    input  wire logic                              i_is_signed,
    // result output
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic                                   o_range_violation,
    output logic                                   o_mask_violation,
    output logic                                   o_run_abort,
    output logic                                   o_not_counter,
    output logic [7:0]                             o_error_count,
    // configuration
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [irmm_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [irmm_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [irmm_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                   pready
);

    import irmm_pkg::*;

    localparam int DEPTH = TYPE_COUNT * ENTRIES_PER_TYPE;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_CALC  = 3'b100
    } t_state;

    t_state r_state, n_state;

    // configuration registers
    logic        r_training_mode;
    logic [7:0]  r_error_limit;
    logic [15:0] r_run_number;

    logic        w_cfg_wr;
    t_reg_index  w_reg_idx;

    assign pready    = 1'b1;
    assign w_reg_idx = t_reg_index'(paddr[3:2]);
    assign w_cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_training_mode <= 1'b1;
            r_error_limit   <= 8'd3;
            r_run_number    <= 16'd0;
        end else if (w_cfg_wr) begin
            case (w_reg_idx)
                REG_TRAINING_MODE: r_training_mode <= pwdata[0];
                REG_ERROR_LIMIT:   r_error_limit   <= pwdata[7:0];
                REG_RUN_NUMBER:    r_run_number    <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_reg_idx)
            REG_TRAINING_MODE: prdata = {31'd0, r_training_mode};
            REG_ERROR_LIMIT:   prdata = {24'd0, r_error_limit};
            REG_RUN_NUMBER:    prdata = {16'd0, r_run_number};
            default:           prdata = '0;
        endcase
    end

    // item capture
    logic          w_in_acc;
    logic          w_in_range;
    logic [AW-1:0] w_addr;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_in_range = (32'(i_type_index) < 32'(TYPE_COUNT)) &&
                        (32'(i_entry_index) < 32'(ENTRIES_PER_TYPE));
    assign w_addr     = AW'(32'(i_type_index) * 32'(ENTRIES_PER_TYPE) + 32'(i_entry_index));

    logic          r_cmd;
    logic          r_sgn;
    logic          r_hit;
    logic [31:0]   r_sample;
    logic [AW-1:0] r_addr;

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_cmd    <= i_cmd;
            r_sgn    <= i_is_signed;
            r_hit    <= w_in_range;
            r_sample <= i_sample;
            r_addr   <= w_addr;
        end
    end

    // clearing pass address
    logic [AW-1:0] r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (r_state == S_CLEAR) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    // memories
    t_ctrl_word    w_ctrl_rd, w_ctrl_wr_calc, w_ctrl_wdata;
    t_data_word    w_data_rd, w_data_wdata;
    logic          w_ctrl_we, w_data_we;
    logic [AW-1:0] w_ctrl_waddr;
    logic          w_go;
    logic          w_ctrl_upd, w_data_upd;

    assign w_go         = (r_state == S_CALC) && (!o_out_valid || i_out_ready);
    assign w_ctrl_we    = (r_state == S_CLEAR) || (w_go && r_hit && w_ctrl_upd);
    assign w_ctrl_waddr = (r_state == S_CLEAR) ? r_clr_addr : r_addr;
    assign w_ctrl_wdata = (r_state == S_CLEAR) ? t_ctrl_word'('0) : w_ctrl_wr_calc;
    assign w_data_we    = w_go && r_hit && w_data_upd;

    irmm_ram #(
        .WIDTH (CTRL_W),
        .DEPTH (DEPTH)
    ) u_ctrl_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_ctrl_we),
        .i_wr_addr (w_ctrl_waddr),
        .i_wr_data (w_ctrl_wdata),
        .i_rd_en   (w_in_acc),
        .i_rd_addr (w_addr),
        .o_rd_data (w_ctrl_rd)
    );

    irmm_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_data_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_data_we),
        .i_wr_addr (r_addr),
        .i_wr_data (w_data_wdata),
        .i_rd_en   (w_in_acc),
        .i_rd_addr (w_addr),
        .o_rd_data (w_data_rd)
    );

    // modify
    logic [31:0] w_val, w_key, w_key_lo, w_key_hi, w_diff;
    logic        w_incr;
    logic        w_sgn, w_restart, w_is_init, w_is_nc, w_do_proc;
    logic        w_lt, w_gt, w_rv, w_mv, w_any, w_ab;
    logic [7:0]  w_cur_cnt, w_new_cnt, w_err_cnt;
    logic [8:0]  w_sum;

    always_comb begin
        w_incr    = (r_cmd == OP_INCREMENT);
        w_val     = w_incr ? (w_data_rd.last + 32'd1) : r_sample;
        w_sgn     = w_incr ? 1'b0 : r_sgn;
        w_restart = (w_ctrl_rd.run < r_run_number);
        w_cur_cnt = w_restart ? 8'd0 : w_ctrl_rd.count;
        w_is_init = !w_incr && (w_ctrl_rd.kind == KIND_UNSET);
        w_is_nc   = w_incr && (w_ctrl_rd.kind != KIND_UNSIGNED);
        w_do_proc = !w_is_init && !w_is_nc;

        w_key    = order_key(w_val, w_sgn);
        w_key_lo = order_key(w_data_rd.low, w_sgn);
        w_key_hi = order_key(w_data_rd.high, w_sgn);
        w_lt     = w_key < w_key_lo;
        w_gt     = w_key > w_key_hi;
        w_diff   = w_data_rd.first ^ w_val;

        w_rv  = !r_training_mode && w_do_proc && (w_lt || w_gt);
        w_mv  = !r_training_mode && w_do_proc && (|(w_diff & w_data_rd.mask));
        w_any = w_rv || w_mv;

        // range counted first, then mask; count only grows, so checking the end suffices
        w_sum     = {1'b0, w_cur_cnt} + 9'(w_rv) + 9'(w_mv);
        w_new_cnt = w_sum[8] ? COUNT_MAX : w_sum[7:0];
        w_ab      = w_any && (w_new_cnt > r_error_limit);
        w_err_cnt = w_any ? w_new_cnt : w_cur_cnt;

        w_ctrl_wr_calc = w_ctrl_rd;
        if (w_is_init) begin
            w_ctrl_wr_calc.kind = w_sgn ? KIND_SIGNED : KIND_UNSIGNED;
        end
        if (w_any) begin
            w_ctrl_wr_calc.count = w_new_cnt;
            w_ctrl_wr_calc.run   = w_restart ? r_run_number : w_ctrl_rd.run;
        end
        w_ctrl_upd = w_is_init || w_any;

        w_data_wdata = w_data_rd;
        if (w_is_init) begin
            w_data_wdata.last  = w_val;
            w_data_wdata.low   = w_val;
            w_data_wdata.high  = w_val;
            w_data_wdata.first = w_val;
            w_data_wdata.mask  = MASK_ONES;
        end else begin
            w_data_wdata.last = w_val;
            if (r_training_mode) begin
                // increments never move the low bound
                if (!w_incr && w_lt) begin
                    w_data_wdata.low = w_val;
                end
                if (w_gt) begin
                    w_data_wdata.high = w_val;
                end
                w_data_wdata.mask = w_data_rd.mask & ~w_diff;
            end
        end
        w_data_upd = w_is_init || w_do_proc;
    end

    // state machine
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (32'(r_clr_addr) == 32'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = S_CALC;
                end
            end
            S_CALC: begin
                if (w_go) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (w_go) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go) begin
            o_range_violation <= r_hit && w_rv;
            o_mask_violation  <= r_hit && w_mv;
            o_run_abort       <= r_hit && w_ab;
            o_not_counter     <= r_hit && w_is_nc;
            o_error_count     <= r_hit ? w_err_cnt : 8'd0;
        end
    end

`ifndef SYNTHESIS
    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("state register not one-hot");

    a_ctrl_write_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl_we |-> (r_state == S_CLEAR || r_state == S_CALC))
        else $error("bookkeeping write outside clear or write-back");

    a_abort_needs_violation: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_run_abort) |-> (o_range_violation || o_mask_violation))
        else $error("abort without a violation");

    a_not_counter_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_not_counter) |-> (!o_range_violation && !o_mask_violation))
        else $error("not_counter together with a violation");

    a_accept_to_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == S_CALC))
        else $error("accepted item did not reach write-back");
`endif

endmodule

`default_nettype wire

/* hdl/irmm_ram.sv */
// simple dual-port ram with registered read
`default_nettype none

module irmm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire
